/* src/framed_byte_receiver_crc8_core_assert.svh */
// Assertion macros used by the byte deframer RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef FRAMED_BYTE_RECEIVER_CRC8_CORE_ASSERT_SVH
`define FRAMED_BYTE_RECEIVER_CRC8_CORE_ASSERT_SVH

// same-cycle implication
`define FRBC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRBC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/frbc_pkg.sv */
// Shared types, constants and the CRC-8 byte step for the byte deframer.
// No dependencies.
`timescale 1ns / 1ps

package frbc_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W           = 6;
	localparam int TEMP_W          = 11;
	localparam int ADDR_W          = 5;
	localparam int DATA_W          = 32;
	localparam int OUT_DATA_W      = 32;

	// register indexes (word address)
	localparam logic [2:0] REG_FLAG     = 3'd0;
	localparam logic [2:0] REG_ESCAPE   = 3'd1;
	localparam logic [2:0] REG_POLY     = 3'd2;
	localparam logic [2:0] REG_CRC_INIT = 3'd3;
	localparam logic [2:0] REG_TEMP_TYP = 3'd4;

	// reset values
	localparam logic [7:0] RST_FLAG     = 8'h7E;
	localparam logic [7:0] RST_ESCAPE   = 8'h7A;
	localparam logic [7:0] RST_POLY     = 8'h31;
	localparam logic [7:0] RST_CRC_INIT = 8'hFF;
	localparam logic [7:0] RST_TEMP_TYP = 8'h23;

	typedef enum logic [2:0] {
		ST_TEMP_OK  = 3'd0,
		ST_TYPE_OK  = 3'd1,
		ST_CRC_ERR  = 3'd2,
		ST_SHORT    = 3'd3,
		ST_OVERFLOW = 3'd4
	} frbc_status_t;

	typedef struct packed {
		logic [7:0] flag_code;
		logic [7:0] escape_code;
		logic [7:0] crc_polynomial;
		logic [7:0] crc_initial;
		logic [7:0] temperature_type;
	} frbc_cfg_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature_eighths;
		logic [LEN_W-1:0]  payload_length;
		logic [7:0]        frame_type;
		frbc_status_t      status;
	} frbc_result_t;

	// MSB-first CRC-8 over one byte, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* src/framed_byte_receiver_crc8_core.sv */
// Closing byte -> input register -> deframer -> output register -> m_tdata.
// One byte per cycle unless the output stalls; the CRC-8 byte step sets the clock limit.
// Each frame yields one result; all other bytes yield none.
// Reset (arst_n low, async): registers to defaults, no frame open, output empty.
// Depends on frbc_pkg, frbc_cfg_regs, frbc_deframer.
`timescale 1ns / 1ps

module framed_byte_receiver_crc8_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
	// frame result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [2:0] status, [10:3] frame_type, [16:11] payload_length,
	// [27:17] temperature_eighths, [31:28] zero
	output logic [frbc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [frbc_pkg::ADDR_W-1:0]       paddr,
	input  logic [frbc_pkg::DATA_W-1:0]       pwdata,
	output logic [frbc_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);
	import frbc_pkg::*;

	frbc_cfg_t    cfg;

	// input register
	logic         valid_s1;
	logic [7:0]   rx_s1;

	// output register
	logic         out_valid_q;
	frbc_result_t out_q;

	logic         advance;
	logic         res_valid;
	frbc_result_t res;

	frbc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The held byte moves through the deframer once the output slot is free
	// or being drained this cycle; otherwise both stages hold.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			rx_s1 <= s_tdata[7:0];
		end
	end

	frbc_deframer u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_valid (advance),
		.rx_byte    (rx_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register: loaded on a frame close, emptied on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(frbc_result_t)){1'b0}}, out_q};

endmodule

/* src/frbc_cfg_regs.sv */
// APB-style configuration register file for the byte deframer.
// Depends on frbc_pkg.
`timescale 1ns / 1ps

module frbc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [frbc_pkg::ADDR_W-1:0]   paddr,
	input  logic [frbc_pkg::DATA_W-1:0]   pwdata,
	output logic [frbc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output frbc_pkg::frbc_cfg_t           cfg
);
	import frbc_pkg::*;

	frbc_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;
	logic [7:0] rd_byte;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_code        <= RST_FLAG;
			cfg_q.escape_code      <= RST_ESCAPE;
			cfg_q.crc_polynomial   <= RST_POLY;
			cfg_q.crc_initial      <= RST_CRC_INIT;
			cfg_q.temperature_type <= RST_TEMP_TYP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FLAG:     cfg_q.flag_code        <= pwdata[7:0];
				REG_ESCAPE:   cfg_q.escape_code      <= pwdata[7:0];
				REG_POLY:     cfg_q.crc_polynomial   <= pwdata[7:0];
				REG_CRC_INIT: cfg_q.crc_initial      <= pwdata[7:0];
				REG_TEMP_TYP: cfg_q.temperature_type <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FLAG:     rd_byte = cfg_q.flag_code;
			REG_ESCAPE:   rd_byte = cfg_q.escape_code;
			REG_POLY:     rd_byte = cfg_q.crc_polynomial;
			REG_CRC_INIT: rd_byte = cfg_q.crc_initial;
			REG_TEMP_TYP: rd_byte = cfg_q.temperature_type;
			default:      rd_byte = 8'h00;
		endcase
	end

	assign prdata = {{(DATA_W - 8){1'b0}}, rd_byte};

endmodule

/* src/frbc_deframer.sv */
// Deframing state, CRC accumulation and frame-close status for one byte per cycle.
// Depends on frbc_pkg and framed_byte_receiver_crc8_core_assert.svh.
`timescale 1ns / 1ps

module frbc_deframer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  frbc_pkg::frbc_cfg_t     cfg,
	input  logic                    byte_valid,
	input  logic [7:0]              rx_byte,
	output logic                    res_valid,
	output frbc_pkg::frbc_result_t  res
);
	import frbc_pkg::*;

	`include "framed_byte_receiver_crc8_core_assert.svh"

	logic             in_frame_q, in_frame_n;
	logic             flag_pend_q, flag_pend_n;
	logic             ovf_q, ovf_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       crc_q, crc_n;
	logic [7:0]       held_q;
	logic [7:0]       first_q [3];

	logic             opening;
	logic             push_en;
	logic [7:0]       push_byte;
	logic [CNT_W-1:0] cnt_base;
	logic             held_we;
	logic [2:0]       first_we;
	logic             is_temp;
	logic             has_type;

	always_comb begin
		in_frame_n  = in_frame_q;
		flag_pend_n = flag_pend_q;
		ovf_n       = ovf_q;
		count_n     = count_q;
		crc_n       = crc_q;
		opening     = 1'b0;
		push_en     = 1'b0;
		push_byte   = rx_byte;
		res_valid   = 1'b0;
		held_we     = 1'b0;
		first_we    = 3'b000;

		if (byte_valid) begin
			if (flag_pend_q && in_frame_q) begin
				flag_pend_n = 1'b0;
				if (rx_byte == cfg.escape_code) begin
					push_en   = 1'b1;
					push_byte = cfg.flag_code;
				end else begin
					in_frame_n = 1'b0;
					res_valid  = 1'b1;
				end
			end else begin
				opening = flag_pend_q && (rx_byte != cfg.flag_code);
				if (opening) begin
					in_frame_n  = 1'b1;
					flag_pend_n = 1'b0;
					ovf_n       = 1'b0;
					count_n     = '0;
					crc_n       = cfg.crc_initial;
				end
				if (rx_byte == cfg.flag_code) begin
					flag_pend_n = 1'b1;
				end else if (in_frame_q || opening) begin
					push_en = 1'b1;
				end
			end
		end

		cnt_base = opening ? '0 : count_q;
		if (push_en) begin
			if (cnt_base >= CNT_W'(MAX_FRAME_BYTES)) begin
				ovf_n = 1'b1;
			end else begin
				// crc runs one byte behind: the held byte may be the received CRC
				if (cnt_base != '0) begin
					crc_n = crc8_step(crc_q, held_q, cfg.crc_polynomial);
				end
				held_we = 1'b1;
				if (cnt_base < CNT_W'(3)) begin
					first_we[cnt_base[1:0]] = 1'b1;
				end
				count_n = cnt_base + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			flag_pend_q <= 1'b0;
			ovf_q       <= 1'b0;
			count_q     <= '0;
			crc_q       <= RST_CRC_INIT;
		end else begin
			in_frame_q  <= in_frame_n;
			flag_pend_q <= flag_pend_n;
			ovf_q       <= ovf_n;
			count_q     <= count_n;
			crc_q       <= crc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (held_we) begin
			held_q <= push_byte;
		end
		for (int i = 0; i < 3; i++) begin
			if (first_we[i]) begin
				first_q[i] <= push_byte;
			end
		end
	end

	// frame-close result from current state
	always_comb begin
		has_type = (count_q != '0);
		is_temp  = has_type && (first_q[0] == cfg.temperature_type);

		res.frame_type          = has_type ? first_q[0] : 8'h00;
		res.temperature_eighths = '0;
		if (32'(count_q) > 32'd63) begin
			res.payload_length = LEN_W'(63);
		end else begin
			res.payload_length = LEN_W'(count_q);
		end

		if (ovf_q) begin
			res.status = ST_OVERFLOW;
		end else if ((count_q < CNT_W'(2)) || (is_temp && (count_q < CNT_W'(4)))) begin
			res.status = ST_SHORT;
		end else if (crc_q != held_q) begin
			res.status = ST_CRC_ERR;
		end else if (is_temp) begin
			res.status              = ST_TEMP_OK;
			res.temperature_eighths = {first_q[1], first_q[2][7:5]};
		end else begin
			res.status = ST_TYPE_OK;
		end
	end

	`FRBC_ASSERT_IMP(a_res_in_frame, res_valid, (in_frame_q && flag_pend_q),
		"result raised outside a pending close")
	`FRBC_ASSERT_NXT(a_res_closes, res_valid, (!in_frame_q && !flag_pend_q),
		"frame still open after close")
	`FRBC_ASSERT_IMP(a_ovf_full, ovf_q, (count_q == CNT_W'(MAX_FRAME_BYTES)),
		"overflow flagged below frame limit")
	`FRBC_ASSERT_IMP(a_ok_len, (res_valid && (res.status == ST_TEMP_OK)),
		(count_q >= CNT_W'(4)), "temperature accepted from short frame")

endmodule
